@@ rtl/table_inverse_linear_interpolator_defines.svh @@
// Assertion macros for the table inverse linear interpolator.
// Included by tili_back, the RTL file that carries concurrent assertions.
`ifndef TABLE_INVERSE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_INVERSE_LINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check that is switched off while reset is high
`define TILI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tili assertion failed");
// check that also holds across reset
`define TILI_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tili assertion failed");
`else
`define TILI_ASSERT(label, clk, rst, prop)
`define TILI_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/tili_pkg.sv @@
// Shared types and constants of the table inverse linear interpolator.
// No dependencies; used by every other RTL file but tili_ifs.
`timescale 1ns / 1ps
`default_nettype none
package tili_pkg;
   localparam int NUM_COLS       = 5;
   localparam int FIELD_BITS     = 48;
   localparam int POS_BITS       = 22;
   localparam int COL_BITS       = 3;
   localparam int IN_ROW_BITS    = 6;
   localparam int FRAC_BITS      = 16;
   localparam int CALC_BITS      = 50;
   localparam int FIRST_ROW_BITS = 6;
   localparam int END_ROW_BITS   = 7;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam int DEF_TABLE_ROWS = 64;
   localparam int DEF_VALUE_BITS = 48;
   localparam int DEF_END_ROW    = 64;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_ROW = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_END_ROW   = 1'b1;

   // request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // the colour column ascends, the others descend
   localparam logic [COL_BITS-1:0] COL_COLOUR = 3'd4;

   typedef struct packed {
      logic                      op;
      logic [COL_BITS-1:0]       key_column;
      logic [COL_BITS-1:0]       out_column;
      logic [IN_ROW_BITS-1:0]    row;
      logic [FIELD_BITS-1:0]     value;
   } cmd_type;
endpackage
`default_nettype wire

@@ rtl/tili_ifs.sv @@
// Request and response channel interfaces of the table inverse linear interpolator.
// Depends on nothing; field widths follow the channel definitions.
`timescale 1ns / 1ps
`default_nettype none
interface tili_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [2:0]         key_column;
   logic [5:0]         row;
   logic signed [47:0] value;
   logic [2:0]         out_column;
   modport source(output valid, op, key_column, row, value, out_column, input ready);
   modport sink(input valid, op, key_column, row, value, out_column, output ready);
endinterface

interface tili_rsp_if;
   logic               valid;
   logic               ready;
   logic [21:0]        position;
   logic signed [47:0] result;
   modport source(output valid, position, result, input ready);
   modport sink(input valid, position, result, output ready);
endinterface
`default_nettype wire

@@ rtl/tili_front.sv @@
// Front end: accepts requests, drops loads that hit no table entry, trims values.
// Depends on tili_pkg and tili_req_if.
`timescale 1ns / 1ps
`default_nettype none
module tili_front #(
   parameter int TABLE_ROWS = tili_pkg::DEF_TABLE_ROWS,
   parameter int VALUE_BITS = tili_pkg::DEF_VALUE_BITS
) (
   tili_req_if.sink         req_if,
   output tili_pkg::cmd_type cmd,
   output logic             push,
   input  logic             full
);
   import tili_pkg::*;

   localparam int VB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

   logic signed [VB-1:0] val_trim;
   logic                 load_ok;

   // value is seen through the stored width, then sign extended again
   assign val_trim = req_if.value[VB-1:0];

   // a load outside the table is accepted and forgotten
   assign load_ok = (32'(req_if.key_column) < NUM_COLS) && (32'(req_if.row) < TABLE_ROWS);

   assign cmd.op         = req_if.op;
   assign cmd.key_column = req_if.key_column;
   assign cmd.out_column = req_if.out_column;
   assign cmd.row        = req_if.row;
   assign cmd.value      = FIELD_BITS'(val_trim);

   assign req_if.ready = !full;
   assign push = req_if.valid && !full && ((req_if.op == OP_QUERY) || load_ok);
endmodule
`default_nettype wire

@@ rtl/tili_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on tili_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tili_queue (
   input  logic             clock,
   input  logic             reset,
   input  tili_pkg::cmd_type push_cmd,
   input  logic             push,
   output logic             full,
   output tili_pkg::cmd_type head,
   output logic             head_valid,
   input  logic             pop
);
   import tili_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && head_valid)) count_in = count_ff + 2'd1;
      else if (!push && pop && head_valid) count_in = count_ff - 2'd1;
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= push_cmd;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop && head_valid) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tili_back.sv @@
// Back end: table memory, row scan, restoring divider, blend and response register.
// Depends on tili_pkg, tili_rsp_if and the assertion macro header.
`include "table_inverse_linear_interpolator_defines.svh"
`timescale 1ns / 1ps
`default_nettype none
module tili_back #(
   parameter int TABLE_ROWS = tili_pkg::DEF_TABLE_ROWS,
   parameter int VALUE_BITS = tili_pkg::DEF_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tili_pkg::FIRST_ROW_BITS-1:0]   first_row,
   input  logic [tili_pkg::END_ROW_BITS-1:0]     end_row,
   input  tili_pkg::cmd_type                     cmd,
   input  logic                                  cmd_valid,
   output logic                                  pop,
   tili_rsp_if.source                            rsp_if
);
   import tili_pkg::*;

   localparam int RW    = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam int HW    = RW + 1;
   localparam int CW    = (HW > END_ROW_BITS) ? HW : END_ROW_BITS;
   localparam int DEPTH = NUM_COLS * TABLE_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = RW + FRAC_BITS;
   localparam int QW    = FRAC_BITS + 1;
   localparam int HIW   = CALC_BITS - FRAC_BITS;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN    = 4'd1;
   localparam logic [3:0] S_DIV_CHK = 4'd2;
   localparam logic [3:0] S_DIV     = 4'd3;
   localparam logic [3:0] S_DIV_END = 4'd4;
   localparam logic [3:0] S_BLEND   = 4'd5;
   localparam logic [3:0] S_BL_RDA  = 4'd6;
   localparam logic [3:0] S_BL_RDB  = 4'd7;
   localparam logic [3:0] S_BL_MAG  = 4'd8;
   localparam logic [3:0] S_BL_MUL  = 4'd9;
   localparam logic [3:0] S_BL_SUM  = 4'd10;
   localparam logic [3:0] S_BL_ADD  = 4'd11;
   localparam logic [3:0] S_LAST_WT = 4'd12;
   localparam logic [3:0] S_DONE    = 4'd13;

   function automatic logic [AW-1:0] ent_addr(input logic [COL_BITS-1:0] col,
                                              input logic [RW-1:0] r);
      return AW'(col) * AW'(TABLE_ROWS) + AW'(r);
   endfunction

   // table memory and its registered read port
   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  mem_we;
   logic signed [CALC_BITS-1:0] rd_ent;

   logic [3:0]  state_ff, state_in;
   cmd_type     cur_ff;
   logic signed [CALC_BITS-1:0] key_ff, prev_ff, a_ff, res_ff;
   logic [HW-1:0]        rd_row_ff;
   logic [RW-1:0]        cmp_row_ff, base_ff, k_ff;
   logic                 cmp_vld_ff, asc_ff, last_sel_ff, up_ff;
   logic [CALC_BITS-1:0] rem_ff, delta_ff, mag_ff, step_ff;
   logic [QW-1:0]        q_ff;
   logic [3:0]           cnt_ff;
   logic [PW-1:0]        pos_ff;
   logic [HIW+FRAC_BITS-1:0] ph_ff;
   logic [2*FRAC_BITS-1:0]   pl_ff;
   logic                 rsp_valid_ff;
   logic [POS_BITS-1:0]  rsp_pos_ff;
   logic [FIELD_BITS-1:0] rsp_res_ff;

   // search window from the row registers
   logic [CW-1:0] lo_c, hi_c, hi_w, last_c;
   logic [RW-1:0] lo_r, last_r;
   assign lo_c = (CW'(first_row) < CW'(TABLE_ROWS - 1)) ? CW'(first_row) : CW'(TABLE_ROWS - 1);
   assign hi_c = (CW'(end_row) < CW'(TABLE_ROWS)) ? CW'(end_row) : CW'(TABLE_ROWS);
   assign hi_w = (hi_c <= lo_c) ? lo_c + CW'(1) : hi_c;
   assign last_c = hi_w - CW'(1);
   assign lo_r   = lo_c[RW-1:0];
   assign last_r = last_c[RW-1:0];

   assign rd_ent = CALC_BITS'(signed'(rd_data_ff));

   // scan compare
   logic is_asc, hit;
   assign is_asc = (cur_ff.key_column == COL_COLOUR);
   assign hit    = cmp_vld_ff && (is_asc ? (key_ff <= rd_ent) : (rd_ent <= key_ff));

   // blend row selection
   logic [RW-1:0] k_raw, k_cl;
   assign k_raw = pos_ff[PW-1:FRAC_BITS];
   assign k_cl  = (k_raw < lo_r) ? lo_r : k_raw;

   // divider step
   logic [CALC_BITS:0] rem2;
   assign rem2 = {rem_ff, 1'b0};

   assign pop = cmd_valid && (state_ff == S_IDLE);

   // memory addressing
   always_comb begin
      mem_we  = pop && (cmd.op == OP_LOAD);
      wr_addr = ent_addr(cmd.key_column, RW'(cmd.row));
      unique case (state_ff)
         S_SCAN:   rd_addr = ent_addr(cur_ff.key_column, rd_row_ff[RW-1:0]);
         S_BL_RDA: rd_addr = ent_addr(cur_ff.out_column, k_ff);
         S_BL_RDB: rd_addr = ent_addr(cur_ff.out_column, RW'(k_ff + RW'(1)));
         default:  rd_addr = ent_addr(cur_ff.out_column, k_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= VALUE_BITS'(signed'(cmd.value));
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop && cmd.op == OP_QUERY)
               state_in = (32'(cmd.key_column) < NUM_COLS) ? S_SCAN : S_BLEND;
         end
         S_SCAN: begin
            if (hit) state_in = (cmp_row_ff == lo_r) ? S_BLEND : S_DIV_CHK;
            else if (cmp_vld_ff && cmp_row_ff == last_r) state_in = S_BLEND;
         end
         S_DIV_CHK: begin
            if (delta_ff == '0 || rem_ff >= delta_ff) state_in = S_DIV_END;
            else state_in = S_DIV;
         end
         S_DIV:     if (cnt_ff == 4'd15) state_in = S_DIV_END;
         S_DIV_END: state_in = S_BLEND;
         S_BLEND: begin
            if (32'(cur_ff.out_column) >= NUM_COLS) state_in = S_DONE;
            else state_in = S_BL_RDA;
         end
         S_BL_RDA:  state_in = last_sel_ff ? S_LAST_WT : S_BL_RDB;
         S_BL_RDB:  state_in = S_BL_MAG;
         S_BL_MAG:  state_in = S_BL_MUL;
         S_BL_MUL:  state_in = S_BL_SUM;
         S_BL_SUM:  state_in = S_BL_ADD;
         S_BL_ADD:  state_in = S_DONE;
         S_LAST_WT: state_in = S_DONE;
         S_DONE:    if (!rsp_valid_ff || rsp_if.ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_if.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_IDLE) cmp_vld_ff <= 1'b0;
         else if (state_ff == S_SCAN && !hit) cmp_vld_ff <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cur_ff    <= cmd;
            key_ff    <= CALC_BITS'(signed'(cmd.value));
            rd_row_ff <= HW'(lo_r);
            pos_ff    <= {last_r, FRAC_BITS'(0)};
         end
         S_SCAN: begin
            if (hit) begin
               asc_ff <= is_asc;
               cnt_ff <= 4'd0;
               q_ff   <= '0;
               pos_ff <= {cmp_row_ff, FRAC_BITS'(0)};
               if (is_asc) begin
                  rem_ff   <= key_ff - prev_ff;
                  delta_ff <= rd_ent - prev_ff;
                  base_ff  <= cmp_row_ff - RW'(1);
               end else begin
                  rem_ff   <= key_ff - rd_ent;
                  delta_ff <= prev_ff - rd_ent;
                  base_ff  <= cmp_row_ff;
               end
            end else if (cmp_vld_ff && cmp_row_ff == last_r) begin
               pos_ff <= {last_r, FRAC_BITS'(0)};
            end else begin
               if (cmp_vld_ff) prev_ff <= rd_ent;
               cmp_row_ff <= rd_row_ff[RW-1:0];
               rd_row_ff  <= rd_row_ff + HW'(1);
            end
         end
         S_DIV_CHK: begin
            // equal span gives a whole row, empty span gives zero
            if (delta_ff == '0) q_ff <= '0;
            else if (rem_ff >= delta_ff) q_ff <= QW'(1) << FRAC_BITS;
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + 4'd1;
            if (rem2 >= {1'b0, delta_ff}) begin
               rem_ff <= CALC_BITS'(rem2 - {1'b0, delta_ff});
               q_ff   <= {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= rem2[CALC_BITS-1:0];
               q_ff   <= {q_ff[QW-2:0], 1'b0};
            end
         end
         S_DIV_END: begin
            if (asc_ff) pos_ff <= {base_ff, FRAC_BITS'(0)} + PW'(q_ff);
            else pos_ff <= {base_ff, FRAC_BITS'(0)} - PW'(q_ff);
         end
         S_BLEND: begin
            res_ff      <= '0;
            last_sel_ff <= (k_cl >= last_r);
            k_ff        <= (k_cl >= last_r) ? last_r : k_cl;
         end
         S_BL_RDB: a_ff <= rd_ent;
         S_BL_MAG: begin
            up_ff  <= (a_ff <= rd_ent);
            mag_ff <= (a_ff <= rd_ent) ? CALC_BITS'(rd_ent - a_ff) : CALC_BITS'(a_ff - rd_ent);
         end
         S_BL_MUL: begin
            ph_ff <= mag_ff[CALC_BITS-1:FRAC_BITS] * pos_ff[FRAC_BITS-1:0];
            pl_ff <= mag_ff[FRAC_BITS-1:0] * pos_ff[FRAC_BITS-1:0];
         end
         S_BL_SUM: step_ff <= CALC_BITS'(ph_ff) + CALC_BITS'(pl_ff[2*FRAC_BITS-1:FRAC_BITS]);
         S_BL_ADD: res_ff <= up_ff ? a_ff + signed'(step_ff) : a_ff - signed'(step_ff);
         S_LAST_WT: res_ff <= rd_ent;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_pos_ff <= POS_BITS'(pos_ff);
               rsp_res_ff <= res_ff[FIELD_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.position = rsp_pos_ff;
   assign rsp_if.result   = rsp_res_ff;

   // restoring divider keeps its remainder below the divisor
   `TILI_ASSERT(a_div_rem, clock, reset, (state_ff == S_DIV) |-> (rem_ff < delta_ff))
   // the scan never compares past the last row in use
   `TILI_ASSERT(a_scan_bound, clock, reset, (state_ff == S_SCAN && cmp_vld_ff) |-> (cmp_row_ff <= last_r))
   // a finished query waits while the response register is still occupied
   `TILI_ASSERT(a_done_hold, clock, reset, (state_ff == S_DONE && rsp_valid_ff && !rsp_if.ready) |=> (state_ff == S_DONE))
   // reset leaves the engine idle with no response pending
   `TILI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff))
endmodule
`default_nettype wire

@@ rtl/table_inverse_linear_interpolator.sv @@
// Top level of the table inverse linear interpolator: row registers and the
// front end, command queue and back end. Depends on tili_pkg, the channel
// interfaces, tili_front, tili_queue and tili_back.
//
// Use: the request channel carries loads (op 0) and queries (op 1). A load
// writes one table entry and gives no response; loads naming a column above
// four or a row past the table are dropped. A query scans the key column from
// the first row in use and returns a fractional row position and the blended
// output column on the response channel, one response per query.
// The csr port writes first_row and end_row; write them only while idle.
// Flow: a load is written to the table memory when the idle back end pops it
// from the queue. A query passes the queue, the row scan, the restoring
// division (none on a first-row hit or no hit) and the blend and output
// register; the row scan goes through the single read port of the table
// memory. One query is worked at a time, while the two-entry queue keeps
// taking requests.
// Reset clears all control state; the table holds unknown data until loaded.
// When the receiver stalls, the response stays in its output register and the
// back end holds the next finished result until that register frees up.
`timescale 1ns / 1ps
`default_nettype none
module table_inverse_linear_interpolator #(
   parameter int TABLE_ROWS = tili_pkg::DEF_TABLE_ROWS,
   parameter int VALUE_BITS = tili_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tili_req_if.sink                             req_if,
   tili_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [tili_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tili_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tili_pkg::*;

   logic [FIRST_ROW_BITS-1:0] first_row_ff;
   logic [END_ROW_BITS-1:0]   end_row_ff;
   cmd_type                   push_cmd, head;
   logic                      push, full, head_valid, pop;

   // row registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff <= '0;
         end_row_ff   <= END_ROW_BITS'(DEF_END_ROW);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_ROW: first_row_ff <= csr_wdata[FIRST_ROW_BITS-1:0];
            CSR_END_ROW:   end_row_ff   <= csr_wdata[END_ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   tili_front #(.TABLE_ROWS(TABLE_ROWS), .VALUE_BITS(VALUE_BITS)) u_front (
      .req_if (req_if),
      .cmd    (push_cmd),
      .push   (push),
      .full   (full)
   );

   tili_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push       (push),
      .full       (full),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   tili_back #(.TABLE_ROWS(TABLE_ROWS), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .first_row (first_row_ff),
      .end_row   (end_row_ff),
      .cmd       (head),
      .cmd_valid (head_valid),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );
endmodule
`default_nettype wire

@@ tb/tb_table_inverse_linear_interpolator.sv @@
// Self-checking testbench for the table inverse linear interpolator: loads tables,
// runs queries under several row windows with random handshake gaps and stalls.
// Depends on tili_pkg, the channel interfaces and the top-level RTL.
`timescale 1ns / 1ps
module tb_table_inverse_linear_interpolator;
   import tili_pkg::*;

   localparam int ROWS           = DEF_TABLE_ROWS;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [POS_BITS-1:0]   position;
      logic [FIELD_BITS-1:0] result;
   } answer_type;

   // Interpolation predictor plus the queue of answers still owed by the block
   class interp_scoreboard;
      logic [63:0] entries [NUM_COLS*ROWS];
      logic [6:0]  first_row;
      logic [6:0]  end_row;
      answer_type  answers[$];
      int          mismatches;
      int          loads;
      int          queries;
      int          responses;

      function new();
         first_row = 0;
         end_row = DEF_END_ROW;
         foreach (entries[i]) entries[i] = '0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [6:0] data);
         if (idx == CSR_FIRST_ROW) first_row = {1'b0, data[5:0]};
         else end_row = data;
      endfunction

      function logic [63:0] entry_at(int c, int r);
         return entries[c*ROWS + r];
      endfunction

      // floor(d * 2^16 / delta), saturating at one whole row
      function logic [63:0] fraction16(logic [63:0] d, logic [63:0] delta);
         logic [63:0] q;
         logic [63:0] rem;
         logic        carry;
         if (delta == 0) return 0;
         if (d >= delta) return 64'd65536;
         q = 0;
         rem = d;
         for (int k = 0; k < FRAC_BITS; k++) begin
            carry = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (carry || rem >= delta) begin
               rem = rem - delta;
               q[0] = 1'b1;
            end
         end
         return q;
      endfunction

      function void note_request(logic op, logic [2:0] kc, logic [5:0] row,
                                 logic [47:0] val, logic [2:0] oc);
         logic [63:0] key, t, p, pos, res, a, b, mag, step, fr;
         int          lo, hi, last, k;
         logic        found, hit, up;
         answer_type  ans;
         key = {{16{val[47]}}, val};
         if (op == OP_LOAD) begin
            loads++;
            if (kc < NUM_COLS) entries[kc*ROWS + row] = key;
            return;
         end
         queries++;
         lo = (first_row < ROWS-1) ? first_row : ROWS-1;
         hi = (end_row < ROWS) ? end_row : ROWS;
         if (hi <= lo) hi = lo + 1;
         last = hi - 1;
         pos = 64'(last) << 16;
         found = 0;
         // scan for the first row that passes the key
         if (kc < NUM_COLS) begin
            for (int i = lo; i < hi && !found; i++) begin
               t = entry_at(kc, i);
               hit = (kc == COL_COLOUR) ? ($signed(key) <= $signed(t))
                                        : ($signed(t) <= $signed(key));
               if (hit) begin
                  found = 1;
                  if (i == lo) pos = 64'(i) << 16;
                  else begin
                     p = entry_at(kc, i-1);
                     if (kc == COL_COLOUR) pos = (64'(i-1) << 16) + fraction16(key-p, t-p);
                     else pos = (64'(i) << 16) - fraction16(key-t, p-t);
                  end
               end
            end
         end
         // blend the output column at the position
         res = 0;
         if (oc < NUM_COLS) begin
            k = int'(pos >> 16);
            if (k < lo) k = lo;
            if (k >= last) res = entry_at(oc, last);
            else begin
               a = entry_at(oc, k);
               b = entry_at(oc, k+1);
               fr = {48'd0, pos[15:0]};
               up = $signed(a) <= $signed(b);
               mag = up ? b - a : a - b;
               step = (mag >> 16) * fr + (((mag & 64'hFFFF) * fr) >> 16);
               res = up ? a + step : a - step;
            end
         end
         ans.position = pos[POS_BITS-1:0];
         ans.result = res[FIELD_BITS-1:0];
         answers.push_back(ans);
      endfunction

      function void check_response(logic [POS_BITS-1:0] pos, logic [FIELD_BITS-1:0] res);
         answer_type want;
         responses++;
         if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: position %h result %h", pos, res);
            return;
         end
         want = answers.pop_front();
         if (want.position !== pos || want.result !== res) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d: position exp %h got %h, result exp %h got %h",
                        responses, want.position, pos, want.result, res);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_FIRST_ROW;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int no_idle = 0;
   int hold_request = 0;
   int idle_cycles = 0;
   int settings = 0;

   interp_scoreboard sb = new();

   tili_req_if req();
   tili_rsp_if rsp();

   table_inverse_linear_interpolator dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // response check and watchdog on accepted traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) sb.check_response(rsp.position, rsp.result);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses owed", sb.answers.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: random gaps per response, plus long hold-offs on request
   initial begin
      int gap;
      rsp.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp.ready = 0;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp.ready = 0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready = 1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   task automatic send_request(logic op, logic [2:0] kc, logic [5:0] row,
                               logic [47:0] val, logic [2:0] oc);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req.op = op;
      req.key_column = kc;
      req.row = row;
      req.value = val;
      req.out_column = oc;
      req.valid = 1;
      do @(posedge clock); while (!req.ready);
      sb.note_request(op, kc, row, val, oc);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [6:0] data);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
      sb.set_register(idx, data);
   endtask

   // wait for every owed response, then let the back end settle
   task automatic drain();
      req.valid = 0;
      while (sb.answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // mode 0 monotone, 1 with flat runs, 2 arbitrary data
   task automatic load_column(int c, int mode);
      logic signed [63:0] v;
      logic [63:0] step;
      v = {{16{1'b0}}, 16'd0, $urandom} << $urandom_range(0, 14);
      if ($urandom_range(0, 1)) v = -v;
      for (int r = 0; r < ROWS; r++) begin
         if (mode == 2) send_request(OP_LOAD, 3'(c), 6'(r), rand48(), 3'($urandom));
         else send_request(OP_LOAD, 3'(c), 6'(r), v[47:0], 3'($urandom));
         step = (mode == 1 && $urandom_range(0, 2) == 0) ? 0
                : 64'($urandom_range(1, 32'hFFFF_FFFF)) >> $urandom_range(0, 30);
         v = (c == COL_COLOUR) ? v + $signed(step) : v - $signed(step);
      end
   endtask

   // query near a stored entry, between entries, or anywhere
   task automatic random_query();
      logic [2:0]  kc, oc;
      logic [63:0] base, nxt;
      logic [47:0] key;
      int          r;
      kc = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      oc = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      r = $urandom_range(0, ROWS-2);
      base = (kc < NUM_COLS) ? sb.entry_at(kc, r) : 64'd0;
      nxt = (kc < NUM_COLS) ? sb.entry_at(kc, r+1) : 64'd0;
      case ($urandom_range(0, 6))
         0: key = base[47:0];
         1: key = base[47:0] + {{32{1'b0}}, 16'($urandom)} - 48'h8000;
         2: key = rand48();
         3: key = 48'h7FFF_FFFF_FFFF;
         4: key = 48'h8000_0000_0000;
         default: key = 48'(($signed(base) + $signed(nxt)) >>> 1) + 48'($urandom_range(0, 3));
      endcase
      send_request(OP_QUERY, kc, 6'($urandom), key, oc);
   endtask

   initial begin
      logic [6:0] firsts [8] = '{0, 63, 0, 5, 40, 0, 20, 63};
      logic [6:0] ends   [8] = '{64, 64, 1, 20, 10, 127, 64, 127};
      int         ph;
      req.valid = 0;
      req.op = OP_LOAD;
      req.key_column = 0;
      req.row = 0;
      req.value = 0;
      req.out_column = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // fill the whole table so that no query reads an unwritten entry
      write_csr(CSR_FIRST_ROW, 0);
      write_csr(CSR_END_ROW, DEF_END_ROW);
      settings++;
      for (int c = 0; c < NUM_COLS; c++) load_column(c, c == 1 ? 1 : 0);

      // directed: extreme entries, keys past both ends, exact and in-between hits
      send_request(OP_LOAD, 0, 0, 48'h7FFF_FFFF_FFFF, 0);
      send_request(OP_LOAD, COL_COLOUR, 0, 48'h8000_0000_0000, 0);
      send_request(OP_LOAD, COL_COLOUR, 63, 48'h7FFF_FFFF_FFFF, 0);
      send_request(OP_LOAD, 5, 3, 48'h1234_5678_9ABC, 0);
      for (int c = 0; c < NUM_COLS; c++) begin
         send_request(OP_QUERY, 3'(c), 0, 48'h7FFF_FFFF_FFFF, 3'((c + 1) % NUM_COLS));
         send_request(OP_QUERY, 3'(c), 0, 48'h8000_0000_0000, 3'(c));
         send_request(OP_QUERY, 3'(c), 0, 48'(sb.entry_at(c, 30)), 3'((c + 2) % NUM_COLS));
         send_request(OP_QUERY, 3'(c), 0,
                      48'((sb.entry_at(c, 30) + sb.entry_at(c, 31)) >> 1),
                      3'((c + 3) % NUM_COLS));
      end
      send_request(OP_QUERY, 7, 0, 48'd0, 2);
      send_request(OP_QUERY, 2, 0, 48'(sb.entry_at(2, 10)), 6);

      // random phases, each under its own row window
      for (ph = 0; ph < 10; ph++) begin
         drain();
         no_idle = (ph == 3);
         if (ph < 8) begin
            write_csr(CSR_FIRST_ROW, firsts[ph]);
            write_csr(CSR_END_ROW, ends[ph]);
         end else begin
            write_csr(CSR_FIRST_ROW, 7'($urandom_range(0, 63)));
            write_csr(CSR_END_ROW, 7'($urandom_range(0, 127)));
         end
         settings++;
         if (ph % 3 == 1) load_column($urandom_range(0, 4), ph == 7 ? 2 : $urandom_range(0, 1));
         if (ph == 2) hold_request = HOLD_CYCLES;
         for (int n = 0; n < 40; n++) begin
            if ($urandom_range(0, 6) == 0)
               send_request(OP_LOAD, 3'($urandom), 6'($urandom),
                            $urandom_range(0, 1) ? rand48()
                            : 48'(sb.entry_at($urandom_range(0, 4), $urandom_range(0, 63))
                                  + $urandom_range(0, 9)), 3'($urandom));
            else random_query();
         end
      end
      drain();

      $display("ran %0d loads and %0d queries over %0d row windows, %0d responses checked",
               sb.loads, sb.queries, settings, sb.responses);
      $display("mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
